@@ src/xcrc_pkg.sv @@
`default_nettype none
package xcrc_pkg;
  localparam logic [7:0] SOH = 8'h01;
  localparam logic [7:0] EOT = 8'h04;
  localparam logic [7:0] ACK = 8'h06;
  localparam logic [7:0] NACK = 8'h15;
  localparam logic [7:0] SYNC = 8'h43;
  localparam logic [1:0] FN_START = 2'd0;
  localparam logic [1:0] FN_BYTE = 2'd1;
  localparam logic [1:0] FN_TICK = 2'd2;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_OK = 2'd2;
  localparam logic [1:0] ST_FAIL = 2'd3;
  localparam logic [1:0] DM_LE = 2'd1;
  localparam logic [1:0] DM_BE = 2'd2;

  // one command from front to back
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       burst;
    logic [1:0] status;
    logic       last;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction
endpackage
`default_nettype wire

@@ src/xmodem_crc_receiver_loader.sv @@
// a reply passes the front's pending register and the back's output register to the result ports
// a new item is taken only after all results of the last (none, one reply, two replies) are passed on
// a good new packet drains 64 writes from the packet store, holding off input until
// the last write is on the result ports; output is held while full and not popped
// rst (synchronous, active high) returns to idle with 255 retries; store not cleared
`default_nettype none
module xmodem_crc_receiver_loader #(
  parameter int ADDR_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [1:0]           func,
  input  wire logic [7:0]           rx_byte,
  output logic                      empty,
  input  wire logic                 pop,
  output logic                      tx_valid,
  output logic [7:0]                tx_byte,
  output logic [1:0]                write_count,
  output logic [ADDR_BITS-1:0]      write_address,
  output logic [15:0]               write_first,
  output logic [7:0]                write_second,
  output logic [1:0]                status,
  output logic                      last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_data
);
  import xcrc_pkg::*;
  logic [1:0] dump_mode;
  logic in_ready, cmd_valid, cmd_ready, burst_busy, start_pulse, mem_we;
  logic [6:0] mem_addr;
  logic [7:0] mem_data;
  cmd_t cmd;

  assign full = !in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) dump_mode <= '0;
    else if (cfg_valid) dump_mode <= cfg_data;
  end

  xcrc_front u_front (
    .clk, .rst, .in_valid(push), .in_ready, .func, .rx_byte, .cmd, .cmd_valid,
    .cmd_ready, .burst_busy, .start_pulse, .mem_we, .mem_addr, .mem_data
  );

  xcrc_back #(.ADDR_BITS(ADDR_BITS)) u_back (
    .clk, .rst, .dump_mode, .cmd, .cmd_valid, .cmd_ready, .burst_busy, .start_pulse,
    .mem_we, .mem_addr, .mem_data, .empty, .pop, .tx_valid, .tx_byte, .write_count,
    .write_address, .write_first, .write_second, .status, .last
  );
endmodule
`default_nettype wire

@@ src/xcrc_front.sv @@
`default_nettype none
module xcrc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        func,
  input  wire logic [7:0]        rx_byte,
  output xcrc_pkg::cmd_t         cmd,
  output logic                   cmd_valid,
  input  wire logic              cmd_ready,
  input  wire logic              burst_busy,
  output logic                   start_pulse,
  output logic                   mem_we,
  output logic [6:0]             mem_addr,
  output logic [7:0]             mem_data
);
  import xcrc_pkg::*;
  typedef enum logic [2:0] {PH_IDLE, PH_SYNC, PH_RECV, PH_DONE, PH_FAIL} phase_t;
  typedef enum logic [1:0] {S_IN, S_OUT} step_t;

  phase_t phase;
  step_t step;
  logic [3:0] sync_tries_left;
  logic [11:0] sync_timer;
  logic [7:0] byte_index;
  logic [6:0] idle_byte_timer;
  logic [10:0] idle_packet_timer;
  logic [7:0] retries_left, previous_block, header_byte, block_number;
  logic [15:0] running_crc, received_crc;
  // pending results: up to two replies
  cmd_t q0, q1;
  logic [1:0] qn;

  function automatic logic [1:0] st_of(input phase_t p);
    case (p)
      PH_SYNC, PH_RECV: return ST_RUN;
      PH_DONE: return ST_OK;
      PH_FAIL: return ST_FAIL;
      default: return ST_IDLE;
    endcase
  endfunction

  assign in_ready = (step == S_IN) && !burst_busy;
  assign cmd = q0;
  assign cmd_valid = (step == S_OUT) && (qn != 2'd0);

  always_ff @(posedge clk) begin
    mem_we <= 1'b0;
    start_pulse <= 1'b0;
    if (rst) begin
      phase <= PH_IDLE; step <= S_IN; sync_tries_left <= '0; sync_timer <= '0;
      byte_index <= '0; idle_byte_timer <= '0; idle_packet_timer <= '0;
      retries_left <= 8'hFF; previous_block <= 8'hFF; header_byte <= '0;
      block_number <= '0; running_crc <= '0; received_crc <= '0; qn <= '0;
    end else if (step == S_IN) begin
      if (in_valid && in_ready) begin : take
        phase_t ph;
        logic [1:0] st_prev;
        logic [7:0] bi, rl;
        logic [6:0] ibt;
        logic [10:0] ipt;
        logic [11:0] stm;
        logic [1:0] n;
        logic r0v, r1v, burst;
        logic [7:0] r0b;
        ph = phase; st_prev = st_of(phase); bi = byte_index; rl = retries_left;
        ibt = idle_byte_timer; ipt = idle_packet_timer; stm = sync_timer;
        n = 0; r0v = 0; r1v = 0; r0b = 0; burst = 0;
        case (func)
          FN_START: begin
            start_pulse <= 1'b1; rl = 8'hFF; previous_block <= 8'hFF;
            bi = 0; ibt = 0; ipt = 0; running_crc <= '0; stm = 0;
            sync_tries_left <= 4'd9; ph = PH_SYNC; n = 1; r0v = 1; r0b = SYNC;
          end
          FN_BYTE: begin
            if (ph == PH_SYNC) begin ph = PH_RECV; bi = 0; end
            if (ph == PH_RECV) begin
              ibt = 0;
              if (bi == 0) begin
                running_crc <= '0; header_byte <= rx_byte;
              end else if (bi == 1) block_number <= rx_byte;
              else if (bi >= 3 && bi <= 130) begin
                mem_we <= 1'b1; mem_addr <= 7'(bi - 8'd3); mem_data <= rx_byte;
                running_crc <= crc_byte(running_crc, rx_byte);
              end else if (bi == 131) received_crc[15:8] <= rx_byte;
              else if (bi == 132) received_crc[7:0] <= rx_byte;
              if (bi == 0 && rx_byte == EOT) begin
                n = 1; r0v = 1; r0b = ACK; ph = PH_DONE;
              end else if (bi >= 132) begin
                bi = 0; ibt = 0; ipt = 0; n = 1; r0v = 1;
                if (header_byte != SOH ||
                    running_crc != {received_crc[15:8], rx_byte}) begin
                  r0b = NACK;
                  if (rl > 0) rl = rl - 1;
                  if (rl == 0) ph = PH_FAIL;
                end else begin
                  rl = 8'hFF; r0b = ACK;
                  if (block_number != previous_block) begin
                    burst = 1; previous_block <= block_number;
                  end
                end
              end else bi = bi + 1;
            end
          end
          FN_TICK: begin
            if (ph == PH_SYNC || ph == PH_RECV) begin
              if (ipt != 11'h7FF) ipt = ipt + 1;
              if (ph == PH_SYNC) begin
                stm = stm + 1;
                if (stm >= 12'd3000) begin
                  stm = 0;
                  if (sync_tries_left > 0) begin
                    sync_tries_left <= sync_tries_left - 1; n = 1; r0v = 1; r0b = SYNC;
                  end else ph = PH_FAIL;
                end
              end else begin
                if (ibt != 7'h7F) ibt = ibt + 1;
                if (ibt > 7'd100) begin
                  ibt = 0; bi = 0; n = 1; r0v = 1; r0b = NACK;
                  if (ipt > 11'd1000) begin
                    if (rl > 0) rl = rl - 1;
                    n = 2; r1v = 1;
                  end
                  if (rl == 0) ph = PH_FAIL;
                end
              end
            end
          end
          default: ;
        endcase
        if (n == 0 && st_of(ph) != st_prev) n = 1;
        q0.tx_valid <= r0v; q0.tx_byte <= r0b; q0.burst <= burst;
        q0.status <= st_of(ph); q0.last <= (n == 1);
        q1.tx_valid <= r1v; q1.tx_byte <= r1v ? NACK : 8'h00; q1.burst <= 1'b0;
        q1.status <= st_of(ph); q1.last <= 1'b1;
        qn <= n; phase <= ph; byte_index <= bi; retries_left <= rl;
        idle_byte_timer <= ibt; idle_packet_timer <= ipt; sync_timer <= stm;
        step <= S_OUT;
      end
    end else begin
      if (qn == 0) step <= S_IN;
      else if (cmd_ready) begin
        q0 <= q1; qn <= qn - 1;
      end
    end
  end
endmodule
`default_nettype wire

@@ src/xcrc_back.sv @@
`default_nettype none
module xcrc_back #(
  parameter int ADDR_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [1:0]           dump_mode,
  input  wire xcrc_pkg::cmd_t       cmd,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  output logic                      burst_busy,
  input  wire logic                 start_pulse,
  input  wire logic                 mem_we,
  input  wire logic [6:0]           mem_addr,
  input  wire logic [7:0]           mem_data,
  output logic                      empty,
  input  wire logic                 pop,
  output logic                      tx_valid,
  output logic [7:0]                tx_byte,
  output logic [1:0]                write_count,
  output logic [ADDR_BITS-1:0]      write_address,
  output logic [15:0]               write_first,
  output logic [7:0]                write_second,
  output logic [1:0]                status,
  output logic                      last
);
  import xcrc_pkg::*;
  logic [7:0] mem_lo [64];
  logic [7:0] mem_hi [64];
  logic [7:0] rd_lo, rd_hi;
  logic [ADDR_BITS-1:0] load_address;
  cmd_t cur;
  logic busy, rd_ok, out_full;
  logic [5:0] k;
  logic bytes;

  assign bytes = !(dump_mode == DM_LE || dump_mode == DM_BE);
  assign burst_busy = busy;
  assign cmd_ready = !busy && (!out_full || pop);
  assign empty = !out_full;

  always_ff @(posedge clk) begin
    if (mem_we && !mem_addr[0]) mem_lo[mem_addr[6:1]] <= mem_data;
    if (mem_we && mem_addr[0]) mem_hi[mem_addr[6:1]] <= mem_data;
    rd_lo <= mem_lo[k];
    rd_hi <= mem_hi[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; rd_ok <= 1'b0; out_full <= 1'b0; k <= '0; load_address <= '0;
    end else begin
      if (out_full && pop) out_full <= 1'b0;
      if (start_pulse) load_address <= '0;
      if (!busy) begin
        if (cmd_valid && cmd_ready) begin
          if (cmd.burst) begin
            busy <= 1'b1; cur <= cmd; k <= '0; rd_ok <= 1'b0;
          end else begin
            out_full <= 1'b1; tx_valid <= cmd.tx_valid; tx_byte <= cmd.tx_byte;
            write_count <= '0; write_address <= '0; write_first <= '0;
            write_second <= '0; status <= cmd.status; last <= cmd.last;
          end
        end
      end else if (!rd_ok) begin
        rd_ok <= 1'b1;
      end else if (!out_full || pop) begin
        out_full <= 1'b1;
        tx_valid <= (k == 6'd63) && cur.tx_valid;
        tx_byte <= (k == 6'd63) ? cur.tx_byte : 8'h00;
        status <= cur.status;
        last <= (k == 6'd63) && cur.last;
        write_address <= load_address;
        if (bytes) begin
          write_count <= 2'd2; write_first <= {8'h00, rd_lo}; write_second <= rd_hi;
          load_address <= load_address + ADDR_BITS'(2);
        end else begin
          write_count <= 2'd1; write_second <= 8'h00;
          write_first <= (dump_mode == DM_LE) ? {rd_hi, rd_lo} : {rd_lo, rd_hi};
          load_address <= load_address + ADDR_BITS'(1);
        end
        rd_ok <= 1'b0;
        if (k == 6'd63) busy <= 1'b0;
        else k <= k + 6'd1;
      end
    end
  end
endmodule
`default_nettype wire
